### rtl/shpow_pkg.sv
// Shared types, SHA-256 constants and round functions for the proof-of-work checker.
// No dependencies; used by every module of the block.
`default_nettype none
package shpow_pkg;

    typedef logic [31:0] word_t;

    // One pipeline item: working variables, feed-forward base, schedule window,
    // and the two nonce bytes that belong to the second block.
    typedef struct packed {
        logic [7:0][31:0]  st;
        logic [7:0][31:0]  base;
        logic [15:0][31:0] w;
        logic [15:0]       tail;
    } cell_data_t;

    localparam int ROUNDS     = 64;
    localparam int SCAN_BYTES = 31;

    // Configuration register indexes
    localparam logic [2:0] REG_DATA0      = 3'd0;
    localparam logic [2:0] REG_DATA1      = 3'd1;
    localparam logic [2:0] REG_DATA2      = 3'd2;
    localparam logic [2:0] REG_DATA3      = 3'd3;
    localparam logic [2:0] REG_DIFFICULTY = 3'd4;
    localparam logic [2:0] REG_THRESHOLD  = 3'd5;

    // Message length in bits (66 bytes), last word of the second block
    localparam word_t MSG_LEN_WORD = 32'h0000_0210;

    localparam word_t K_ROUND [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0][31:0] H_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t rotr(input word_t x, input int n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t ch_f(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t maj_f(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage
`default_nettype wire

### rtl/sha256_pow_checker_unit.sv
// Top level: config registers, 128-cell SHA-256 round chain, digest stage, work scan.
// Depends on shpow_pkg, shpow_round_cell, shpow_work_scan.
//
//  channel | signals                                   | direction
//  input   | in_valid, in_ready, nonce_word0..3        | nonce item in
//  output  | out_valid, out_ready, work_value, meets.. | result item out
//  config  | cfg_we, cfg_index, cfg_data               | register write
//
// One item accepted per cycle while the chain advances; each passes 128 round cells,
// digest add, byte scan and output register. The whole chain advances together when
// the output register is empty or being taken, so in_ready follows out_ready.
// Reset clears valid bits and config registers; no clearing pass.
`default_nettype none
module sha256_pow_checker_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] nonce_word0,
    input  wire logic [63:0] nonce_word1,
    input  wire logic [63:0] nonce_word2,
    input  wire logic [63:0] nonce_word3,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      work_value,
    output logic             meets_share
);
    import shpow_pkg::*;

    localparam int STAGES = 2 * ROUNDS;

    logic [3:0][63:0] data_reg;
    logic [15:0]      difficulty_reg;
    logic [15:0]      threshold_reg;
    logic             advance;
    logic [511:0]     msg1;
    logic             stg_valid [STAGES + 1];
    cell_data_t       stg_data  [STAGES + 1];
    logic             cell_valid_in [STAGES];
    cell_data_t       cell_data_in  [STAGES];
    logic [7:0][31:0] mid;
    cell_data_t       blk2;
    logic             dg_valid_reg;
    logic [255:0]     digest_reg;
    logic [255:0]     digest_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg       <= '0;
            difficulty_reg <= '0;
            threshold_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DATA0:      data_reg[0]    <= cfg_data;
                REG_DATA1:      data_reg[1]    <= cfg_data;
                REG_DATA2:      data_reg[2]    <= cfg_data;
                REG_DATA3:      data_reg[3]    <= cfg_data;
                REG_DIFFICULTY: difficulty_reg <= cfg_data[15:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_ready = advance;

    // First message block: data, difficulty, nonce bytes 0..29
    assign msg1 = {data_reg[0], data_reg[1], data_reg[2], data_reg[3], difficulty_reg,
                   nonce_word0, nonce_word1, nonce_word2, nonce_word3[63:16]};

    always_comb
    begin
        stg_valid[0]     = in_valid;
        stg_data[0].st   = H_INIT;
        stg_data[0].base = H_INIT;
        stg_data[0].tail = nonce_word3[15:0];
        for (int i = 0; i < 16; i++)
        begin
            stg_data[0].w[i] = msg1[511 - 32 * i -: 32];
        end
    end

    // Block boundary: feed-forward, then second padded block
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mid[i] = stg_data[ROUNDS].st[i] + stg_data[ROUNDS].base[i];
        end
        blk2.st    = mid;
        blk2.base  = mid;
        blk2.tail  = stg_data[ROUNDS].tail;
        blk2.w     = '0;
        blk2.w[0]  = {stg_data[ROUNDS].tail, 8'h80, 8'h00};
        blk2.w[15] = MSG_LEN_WORD;
    end

    // Round chain
    for (genvar c = 0; c < STAGES; c++)
    begin : g_cell
        assign cell_valid_in[c] = stg_valid[c];
        assign cell_data_in[c]  = (c == ROUNDS) ? blk2 : stg_data[c];

        shpow_round_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .round_idx (6'(c % ROUNDS)),
            .valid_in  (cell_valid_in[c]),
            .data_in   (cell_data_in[c]),
            .valid_out (stg_valid[c + 1]),
            .data_out  (stg_data[c + 1])
        );
    end

    // Final feed-forward into the digest register
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digest_next[255 - 32 * i -: 32] = stg_data[STAGES].st[i]
                                            + stg_data[STAGES].base[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dg_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            dg_valid_reg <= stg_valid[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            digest_reg <= digest_next;
        end
    end

    shpow_work_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .dg_valid    (dg_valid_reg),
        .digest      (digest_reg),
        .threshold   (threshold_reg),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .work_value  (work_value),
        .meets_share (meets_share)
    );

endmodule
`default_nettype wire

### rtl/shpow_round_cell.sv
// One SHA-256 round cell: performs a round and slides the schedule window.
// Depends on shpow_pkg.
`default_nettype none
module shpow_round_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic [5:0]               round_idx,
    input  wire logic                     valid_in,
    input  wire shpow_pkg::cell_data_t    data_in,
    output logic                          valid_out,
    output shpow_pkg::cell_data_t         data_out
);
    import shpow_pkg::*;

    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;
    word_t      t1;
    word_t      t2;
    word_t      w_new;

    // Round arithmetic and schedule expansion
    always_comb
    begin
        t1 = data_in.st[7] + big_sig1(data_in.st[4])
           + ch_f(data_in.st[4], data_in.st[5], data_in.st[6])
           + K_ROUND[round_idx] + data_in.w[0];
        t2 = big_sig0(data_in.st[0]) + maj_f(data_in.st[0], data_in.st[1], data_in.st[2]);
        w_new = data_in.w[0] + small_sig0(data_in.w[1]) + data_in.w[9]
              + small_sig1(data_in.w[14]);

        data_next       = data_in;
        data_next.st[7] = data_in.st[6];
        data_next.st[6] = data_in.st[5];
        data_next.st[5] = data_in.st[4];
        data_next.st[4] = data_in.st[3] + t1;
        data_next.st[3] = data_in.st[2];
        data_next.st[2] = data_in.st[1];
        data_next.st[1] = data_in.st[0];
        data_next.st[0] = t1 + t2;
        data_next.w     = {w_new, data_in.w[15:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule
`default_nettype wire

### rtl/shpow_work_scan.sv
// Leading-zero scan of the digest, work value and threshold compare, output register.
// Depends on shpow_pkg.
`default_nettype none
module shpow_work_scan (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          dg_valid,
    input  wire logic [255:0]  digest,
    input  wire logic [15:0]   threshold,
    output logic               advance,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        work_value,
    output logic               meets_share
);
    import shpow_pkg::*;

    logic        scan_valid_reg;
    logic [4:0]  idx_reg;
    logic [7:0]  cur_reg;
    logic [7:0]  nxt_reg;
    logic [4:0]  idx_next;
    logic [7:0]  cur_next;
    logic [7:0]  nxt_next;
    logic        out_valid_reg;
    logic [15:0] work_reg;
    logic        meets_reg;
    logic [2:0]  lz;
    logic [15:0] pair_shift;
    logic [7:0]  zeros;
    logic [15:0] work_next;

    assign advance = !out_valid_reg || out_ready;

    // First nonzero byte among the first 31; index 31 when all are zero
    always_comb
    begin
        idx_next = 5'(SCAN_BYTES);
        for (int j = SCAN_BYTES - 1; j >= 0; j--)
        begin
            if (digest[255 - 8 * j -: 8] != 8'h00)
            begin
                idx_next = 5'(j);
            end
        end
        cur_next = digest[255 - 8 * int'(idx_next) -: 8];
        nxt_next = (idx_next == 5'(SCAN_BYTES)) ? 8'h00
                 : digest[247 - 8 * int'(idx_next) -: 8];
    end

    // Bit position inside the byte, then the work value
    // (no shift when the first 31 bytes are all zero: the last byte is taken as is)
    always_comb
    begin
        lz = 3'd0;
        if (idx_reg != 5'(SCAN_BYTES))
        begin
            for (int b = 0; b < 8; b++)
            begin
                if (cur_reg[b])
                begin
                    lz = 3'(7 - b);
                end
            end
        end
        pair_shift = {cur_reg, nxt_reg} << lz;
        zeros      = {idx_reg, 3'b000} + {5'd0, lz};
        work_next  = {zeros, pair_shift[15:8]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            scan_valid_reg <= dg_valid;
            out_valid_reg  <= scan_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg   <= idx_next;
            cur_reg   <= cur_next;
            nxt_reg   <= nxt_next;
            work_reg  <= work_next;
            meets_reg <= work_next > threshold;
        end
    end

    assign out_valid   = out_valid_reg;
    assign work_value  = work_reg;
    assign meets_share = meets_reg;

endmodule
`default_nettype wire
